/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the front, queue and back RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, off while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication: antecedent, then consequent on the next edge.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/nir_pkg.sv */
package nir_pkg;

	localparam int MAX_SYMBOLS    = 64;
	localparam int CNT_W          = 7;
	localparam int DUR_W          = 15;
	localparam int DATA_BITS      = 32;
	localparam int HALF_BITS      = 16;
	localparam int FRAME_SYMBOLS  = 34;
	localparam int REPEAT_SYMBOLS = 2;
	localparam int LAST_DATA_IDX  = 32;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QPTR_W         = 1;
	localparam int QCNT_W         = 2;
	localparam int ADDR_W         = 5;
	localparam int APB_W          = 32;

	localparam logic [DUR_W-1:0] RST_LEAD_MARK    = 15'd9000;
	localparam logic [DUR_W-1:0] RST_LEAD_SPACE   = 15'd4500;
	localparam logic [DUR_W-1:0] RST_BIT_MARK     = 15'd560;
	localparam logic [DUR_W-1:0] RST_ZERO_SPACE   = 15'd560;
	localparam logic [DUR_W-1:0] RST_ONE_SPACE    = 15'd1690;
	localparam logic [DUR_W-1:0] RST_REPEAT_SPACE = 15'd2250;
	localparam logic [DUR_W-1:0] RST_TOLERANCE    = 15'd200;

	typedef enum logic [2:0] {
		ST_FRAME_OK   = 3'd0,
		ST_FRAME_BAD  = 3'd1,
		ST_REPEAT_OK  = 3'd2,
		ST_REPEAT_BAD = 3'd3,
		ST_UNKNOWN    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		REG_LEAD_MARK    = 3'd0,
		REG_LEAD_SPACE   = 3'd1,
		REG_BIT_MARK     = 3'd2,
		REG_ZERO_SPACE   = 3'd3,
		REG_ONE_SPACE    = 3'd4,
		REG_REPEAT_SPACE = 3'd5,
		REG_TOLERANCE    = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [DUR_W-1:0] lead_mark;
		logic [DUR_W-1:0] lead_space;
		logic [DUR_W-1:0] bit_mark;
		logic [DUR_W-1:0] zero_space;
		logic [DUR_W-1:0] one_space;
		logic [DUR_W-1:0] repeat_space;
		logic [DUR_W-1:0] tolerance;
	} timing_t;

	// One finished burst, handed from the front to the back.
	typedef struct packed {
		status_t               status;
		logic [DATA_BITS-1:0]  bits;
	} burst_req_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

/* hw/rtl/nir_front.sv */
`include "assert_macros.svh"

module nir_front import nir_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  timing_t             timing,
	input  logic                sym_valid,
	input  logic [DUR_W-1:0]    mark_duration,
	input  logic [DUR_W-1:0]    space_duration,
	input  logic                end_of_burst,
	input  logic                queue_full,
	output logic                sym_stall,
	output logic                push,
	output burst_req_t          push_req
);

	logic [CNT_W-1:0]     count_q;
	logic                 good_q;
	logic [DATA_BITS-1:0] shift_q;
	logic                 rep_q;

	logic [CNT_W-1:0]     count_d;
	logic [CNT_W:0]       count_inc;
	logic                 good_d;
	logic [DATA_BITS-1:0] shift_d;
	logic                 rep_d;
	logic                 accept;
	logic                 lm_ok, ls_ok, rs_ok, bm_ok, zs_ok, os_ok;
	status_t              status_d;

	// Strict window; a tolerance above the spec value never matches.
	function automatic logic in_win(input logic [DUR_W-1:0] d, input logic [DUR_W-1:0] s,
			input logic [DUR_W-1:0] t);
		logic [DUR_W:0] hi;
		logic [DUR_W:0] lo;
		hi = {1'b0, s} + {1'b0, t};
		lo = {1'b0, s} - {1'b0, t};
		return (t <= s) && ({1'b0, d} < hi) && ({1'b0, d} > lo);
	endfunction

	assign sym_stall = queue_full;
	assign accept    = sym_valid && !queue_full;

	always_comb begin
		lm_ok = in_win(mark_duration, timing.lead_mark, timing.tolerance);
		bm_ok = in_win(mark_duration, timing.bit_mark, timing.tolerance);
		ls_ok = in_win(space_duration, timing.lead_space, timing.tolerance);
		rs_ok = in_win(space_duration, timing.repeat_space, timing.tolerance);
		zs_ok = in_win(space_duration, timing.zero_space, timing.tolerance);
		os_ok = in_win(space_duration, timing.one_space, timing.tolerance);
	end

	always_comb begin
		good_d  = good_q;
		shift_d = shift_q;
		rep_d   = rep_q;
		if (count_q == '0) begin
			rep_d = lm_ok && rs_ok;
			if (!(lm_ok && ls_ok))
				good_d = 1'b0;
		end else if (count_q <= CNT_W'(LAST_DATA_IDX)) begin
			// a one wins over a zero when both windows match
			if (!(bm_ok && (os_ok || zs_ok)))
				good_d = 1'b0;
			shift_d = {bm_ok && os_ok, shift_q[DATA_BITS-1:1]};
		end
		count_inc = {1'b0, count_q} + 1'b1;
		if (count_inc > (CNT_W+1)'(MAX_SYMBOLS))
			count_d = CNT_W'(MAX_SYMBOLS);
		else
			count_d = count_inc[CNT_W-1:0];
	end

	always_comb begin
		if (count_d == CNT_W'(FRAME_SYMBOLS))
			status_d = good_d ? ST_FRAME_OK : ST_FRAME_BAD;
		else if (count_d == CNT_W'(REPEAT_SYMBOLS))
			status_d = rep_d ? ST_REPEAT_OK : ST_REPEAT_BAD;
		else
			status_d = ST_UNKNOWN;
	end

	assign push            = accept && end_of_burst;
	assign push_req.status = status_d;
	assign push_req.bits   = shift_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			good_q  <= 1'b1;
			shift_q <= '0;
			rep_q   <= 1'b0;
		end else if (accept) begin
			if (end_of_burst) begin
				count_q <= '0;
				good_q  <= 1'b1;
				shift_q <= '0;
				rep_q   <= 1'b0;
			end else begin
				count_q <= count_d;
				good_q  <= good_d;
				shift_q <= shift_d;
				rep_q   <= rep_d;
			end
		end
	end

	`ASSERT_CLK(a_count_sat, count_q <= CNT_W'(MAX_SYMBOLS), "symbol count past saturation")
	`ASSERT_NEXT(a_burst_clear, push, (count_q == '0) && good_q && (shift_q == '0),
		"burst state not cleared after last symbol")

endmodule

/* hw/rtl/nir_queue.sv */
`include "assert_macros.svh"

module nir_queue import nir_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  burst_req_t  push_req,
	input  logic        pop,
	output burst_req_t  head,
	output queue_stat_t stat
);

	burst_req_t        mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;
	logic              do_push;
	logic              do_pop;

	assign stat.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_q] <= push_req;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push)
				wr_q <= wr_q + 1'b1;
			if (do_pop)
				rd_q <= rd_q + 1'b1;
			if (do_push && !do_pop)
				cnt_q <= cnt_q + 1'b1;
			else if (do_pop && !do_push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	`ASSERT_CLK(a_q_bound, cnt_q <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
	`ASSERT_NEXT(a_q_fill, do_push && !do_pop, !stat.empty, "pushed request vanished")

endmodule

/* hw/rtl/nir_back.sv */
`include "assert_macros.svh"

module nir_back import nir_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  burst_req_t           head,
	input  queue_stat_t          qstat,
	output logic                 pop,
	output logic                 res_valid,
	input  logic                 res_stall,
	output logic [2:0]           status,
	output logic [HALF_BITS-1:0] address,
	output logic [HALF_BITS-1:0] command
);

	logic                 valid_q;
	status_t              status_q;
	logic [HALF_BITS-1:0] addr_q;
	logic [HALF_BITS-1:0] cmd_q;

	// Output slot refills when empty or when its request is taken this edge.
	assign pop       = !qstat.empty && (!valid_q || !res_stall);
	assign res_valid = valid_q;
	assign status    = status_q;
	assign address   = addr_q;
	assign command   = cmd_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			addr_q  <= '0;
			cmd_q   <= '0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				if (head.status == ST_FRAME_OK) begin
					addr_q <= head.bits[HALF_BITS-1:0];
					cmd_q  <= head.bits[DATA_BITS-1:HALF_BITS];
				end
			end else if (!res_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			status_q <= head.status;
	end

	`ASSERT_NEXT(a_saved_hold, pop && (head.status != ST_FRAME_OK),
		$stable(addr_q) && $stable(cmd_q), "stored address changed on a non-frame result")

endmodule

/* hw/rtl/nec_ir_frame_decoder_unit.sv */
// NEC infrared frame decoder.
// Input channel: one pulse symbol per request (mark_duration, space_duration,
// end_of_burst), taken when in_valid is high and in_stall is low.
// Output channel: one result (status, address, command) per burst, presented
// on out_valid and held while out_stall is high.
// Throughput: one symbol per cycle. in_stall rises only when the two-entry
// burst queue between front and back is full, which only an output stall can cause.
// After the last symbol is taken, the front classifies the burst and enqueues it;
// the back then loads it into the output slot, raising out_valid, once the slot is free.
// Timing registers sit on an APB port, 4-byte spaced, pready tied high;
// write them only while no burst is in flight.
// Reset clears the burst state, the stored address and command, the queue and
// the output slot, and loads the standard NEC timings with tolerance 200.
// While the receiver stalls, the held result stays put, the queue fills and
// then input is stalled.
module nec_ir_frame_decoder_unit import nir_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_W-1:0]    paddr,
	input  logic [APB_W-1:0]     pwdata,
	output logic [APB_W-1:0]     prdata,
	output logic                 pready,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [DUR_W-1:0]     mark_duration,
	input  logic [DUR_W-1:0]     space_duration,
	input  logic                 end_of_burst,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [2:0]           status,
	output logic [HALF_BITS-1:0] address,
	output logic [HALF_BITS-1:0] command
);

	timing_t     timing_q;
	reg_idx_t    reg_idx;
	logic        cfg_wr;
	logic        push;
	logic        pop;
	burst_req_t  push_req;
	burst_req_t  head;
	queue_stat_t qstat;
	logic [DUR_W-1:0] rd_val;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timing_q.lead_mark    <= RST_LEAD_MARK;
			timing_q.lead_space   <= RST_LEAD_SPACE;
			timing_q.bit_mark     <= RST_BIT_MARK;
			timing_q.zero_space   <= RST_ZERO_SPACE;
			timing_q.one_space    <= RST_ONE_SPACE;
			timing_q.repeat_space <= RST_REPEAT_SPACE;
			timing_q.tolerance    <= RST_TOLERANCE;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_LEAD_MARK:    timing_q.lead_mark    <= pwdata[DUR_W-1:0];
				REG_LEAD_SPACE:   timing_q.lead_space   <= pwdata[DUR_W-1:0];
				REG_BIT_MARK:     timing_q.bit_mark     <= pwdata[DUR_W-1:0];
				REG_ZERO_SPACE:   timing_q.zero_space   <= pwdata[DUR_W-1:0];
				REG_ONE_SPACE:    timing_q.one_space    <= pwdata[DUR_W-1:0];
				REG_REPEAT_SPACE: timing_q.repeat_space <= pwdata[DUR_W-1:0];
				REG_TOLERANCE:    timing_q.tolerance    <= pwdata[DUR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LEAD_MARK:    rd_val = timing_q.lead_mark;
			REG_LEAD_SPACE:   rd_val = timing_q.lead_space;
			REG_BIT_MARK:     rd_val = timing_q.bit_mark;
			REG_ZERO_SPACE:   rd_val = timing_q.zero_space;
			REG_ONE_SPACE:    rd_val = timing_q.one_space;
			REG_REPEAT_SPACE: rd_val = timing_q.repeat_space;
			REG_TOLERANCE:    rd_val = timing_q.tolerance;
			default:          rd_val = '0;
		endcase
	end

	assign prdata = APB_W'(rd_val);

	nir_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.timing         (timing_q),
		.sym_valid      (in_valid),
		.mark_duration  (mark_duration),
		.space_duration (space_duration),
		.end_of_burst   (end_of_burst),
		.queue_full     (qstat.full),
		.sym_stall      (in_stall),
		.push           (push),
		.push_req       (push_req)
	);

	nir_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_req (push_req),
		.pop      (pop),
		.head     (head),
		.stat     (qstat)
	);

	nir_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.qstat     (qstat),
		.pop       (pop),
		.res_valid (out_valid),
		.res_stall (out_stall),
		.status    (status),
		.address   (address),
		.command   (command)
	);

endmodule

/* dv/nec_ir_frame_decoder_unit_test.sv */
`timescale 1ns / 1ps

module nec_ir_frame_decoder_unit_test;
	import nir_pkg::*;

	// no request taken on either side for this many cycles ends the run
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 8;
	localparam int SETTLE       = 4;
	localparam int PHASES       = 8;
	localparam int PHASE_ITEMS  = 10;
	localparam int PHASE_BURSTS = 1;
	localparam int MAX_SHOWN    = 10;
	localparam int DIR_ROWS     = 19;
	localparam logic [ADDR_W-1:0] ADDR_UNUSED = 5'd28;
	localparam logic [DUR_W-1:0]  DUR_MAX     = '1;

	typedef struct packed {
		logic [DUR_W-1:0] mark;
		logic [DUR_W-1:0] space;
		logic             eob;
	} symbol_t;

	typedef struct packed {
		status_t              status;
		logic [HALF_BITS-1:0] address;
		logic [HALF_BITS-1:0] command;
	} decode_t;

	typedef struct packed {
		int               len;
		logic [31:0]      data;
		int               hit;       // symbol to overwrite, -1 for none
		logic [DUR_W-1:0] hit_mark;
		logic [DUR_W-1:0] hit_space;
		logic             known;     // decode below is typed in
		decode_t          want;
	} burst_row_t;

	logic                 clk            = 1'b0;
	logic                 arst_n         = 1'b0;
	logic                 psel           = 1'b0;
	logic                 penable        = 1'b0;
	logic                 pwrite         = 1'b0;
	logic [ADDR_W-1:0]    paddr          = '0;
	logic [APB_W-1:0]     pwdata         = '0;
	logic [APB_W-1:0]     prdata;
	logic                 pready;
	logic                 in_valid       = 1'b0;
	logic                 in_stall;
	logic [DUR_W-1:0]     mark_duration  = '0;
	logic [DUR_W-1:0]     space_duration = '0;
	logic                 end_of_burst   = 1'b0;
	logic                 out_valid;
	logic                 out_stall      = 1'b0;
	logic [2:0]           status;
	logic [HALF_BITS-1:0] address;
	logic [HALF_BITS-1:0] command;

	// decoder state as seen from outside
	timing_t              tim;
	logic [CNT_W-1:0]     sym_cnt;
	logic                 frame_ok;
	logic [31:0]          bits_sr;
	logic                 lead_rep;
	logic [HALF_BITS-1:0] addr_q;
	logic [HALF_BITS-1:0] cmd_q;

	decode_t decodes_due[$];
	symbol_t burst_q[$];
	int      mismatches = 0;
	int      decoded    = 0;
	int      sent       = 0;
	int      idle_pct   = 0;
	int      stall_pct  = 0;
	int      quiet      = 0;

	burst_row_t burst_tab [DIR_ROWS] = '{
		'{1,   32'h0,         0, 15'd0,   15'd0,   1'b1, '{ST_UNKNOWN, 16'h0, 16'h0}},
		'{1,   32'h0,         0, DUR_MAX, DUR_MAX, 1'b1, '{ST_UNKNOWN, 16'h0, 16'h0}},
		'{2,   32'h0,        -1, 15'd0,   15'd0,   1'b1, '{ST_REPEAT_OK, 16'h0, 16'h0}},
		'{34,  32'h1234_5678, -1, 15'd0, 15'd0,   1'b1, '{ST_FRAME_OK, 16'h5678, 16'h1234}},
		'{34,  32'hFFFF_FFFF, -1, 15'd0, 15'd0,   1'b1, '{ST_FRAME_OK, 16'hFFFF, 16'hFFFF}},
		'{34,  32'h0,        -1, 15'd0,   15'd0,   1'b1, '{ST_FRAME_OK, 16'h0, 16'h0}},
		'{34,  32'hA5C3_0F96, 0, 15'd0,   15'd4500, 1'b1, '{ST_FRAME_BAD, 16'h0, 16'h0}},
		'{34,  32'hA5C3_0F96, 0, 15'd9000, 15'd2250, 1'b1, '{ST_FRAME_BAD, 16'h0, 16'h0}},
		'{34,  32'hA5C3_0F96, 33, DUR_MAX, DUR_MAX, 1'b1, '{ST_FRAME_OK, 16'h0F96, 16'hA5C3}},
		'{34,  32'h1,        17, 15'd560, 15'd1100, 1'b1, '{ST_FRAME_BAD, 16'h0F96, 16'hA5C3}},
		'{34,  32'h8000_0000, 5, 15'd759, 15'd361,  1'b0, '{ST_UNKNOWN, 16'h0, 16'h0}},
		'{34,  32'h8000_0000, 5, 15'd760, 15'd560,  1'b0, '{ST_UNKNOWN, 16'h0, 16'h0}},
		'{34,  32'h8000_0000, 32, 15'd560, 15'd1889, 1'b0, '{ST_UNKNOWN, 16'h0, 16'h0}},
		'{2,   32'h0,         0, 15'd0,   15'd2250, 1'b0, '{ST_UNKNOWN, 16'h0, 16'h0}},
		'{2,   32'h0,         1, 15'd0,   DUR_MAX,  1'b0, '{ST_UNKNOWN, 16'h0, 16'h0}},
		'{2,   32'h0,         0, 15'd9000, 15'd4500, 1'b0, '{ST_UNKNOWN, 16'h0, 16'h0}},
		'{33,  32'h5555_AAAA, -1, 15'd0,  15'd0,    1'b0, '{ST_UNKNOWN, 16'h0, 16'h0}},
		'{35,  32'h5555_AAAA, -1, 15'd0,  15'd0,    1'b0, '{ST_UNKNOWN, 16'h0, 16'h0}},
		// a counter that wraps instead of saturating sees 34 here
		'{162, 32'h0F0F_F0F0, -1, 15'd0,  15'd0,    1'b0, '{ST_UNKNOWN, 16'h0, 16'h0}}
	};

	nec_ir_frame_decoder_unit dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.prdata         (prdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.mark_duration  (mark_duration),
		.space_duration (space_duration),
		.end_of_burst   (end_of_burst),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.status         (status),
		.address        (address),
		.command        (command)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// strict window; a tolerance above the spec value never matches
	function automatic logic in_win(input logic [DUR_W-1:0] d, input logic [DUR_W-1:0] s);
		int unsigned tol;
		tol = tim.tolerance;
		if (tol > s)
			return 1'b0;
		return (d < s + tol) && (d > s - tol);
	endfunction

	function automatic logic [DUR_W-1:0] near(input logic [DUR_W-1:0] s, input logic jit);
		int v;
		int t;
		t = tim.tolerance;
		v = s;
		if (jit && t > 1)
			v = v + int'($urandom_range(0, 2 * t - 2)) - (t - 1);
		if (v < 0)
			v = 0;
		if (v > int'(DUR_MAX))
			v = DUR_MAX;
		return v[DUR_W-1:0];
	endfunction

	task automatic decode_symbol(input symbol_t sym, input logic known, input decode_t want);
		logic    mark_ok;
		logic    b;
		decode_t got;
		if (sym_cnt == 0) begin
			lead_rep = in_win(sym.mark, tim.lead_mark) && in_win(sym.space, tim.repeat_space);
			if (!(in_win(sym.mark, tim.lead_mark) && in_win(sym.space, tim.lead_space)))
				frame_ok = 1'b0;
		end else if (sym_cnt <= LAST_DATA_IDX) begin
			mark_ok = in_win(sym.mark, tim.bit_mark);
			// one wins where both space windows match
			if (mark_ok && in_win(sym.space, tim.one_space)) begin
				b = 1'b1;
			end else begin
				b = 1'b0;
				if (!(mark_ok && in_win(sym.space, tim.zero_space)))
					frame_ok = 1'b0;
			end
			bits_sr = {b, bits_sr[31:1]};
		end
		if (sym_cnt < MAX_SYMBOLS)
			sym_cnt++;
		if (sym.eob) begin
			if (sym_cnt == FRAME_SYMBOLS) begin
				if (frame_ok) begin
					addr_q = bits_sr[15:0];
					cmd_q = bits_sr[31:16];
					got.status = ST_FRAME_OK;
				end else begin
					got.status = ST_FRAME_BAD;
				end
			end else if (sym_cnt == REPEAT_SYMBOLS) begin
				got.status = lead_rep ? ST_REPEAT_OK : ST_REPEAT_BAD;
			end else begin
				got.status = ST_UNKNOWN;
			end
			got.address = addr_q;
			got.command = cmd_q;
			decodes_due.push_back(known ? want : got);
			sym_cnt = '0;
			frame_ok = 1'b1;
			bits_sr = '0;
			lead_rep = 1'b0;
		end
	endtask

	// called and returns at a falling edge
	task automatic apb_access(input logic wr, input logic [ADDR_W-1:0] a,
			input logic [APB_W-1:0] d, output logic [APB_W-1:0] rd);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= a;
		pwdata <= d;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_timing(input reg_idx_t r, input logic [DUR_W-1:0] v);
		logic [APB_W-1:0] rd;
		// junk above the field must be dropped
		apb_access(1'b1, {r, 2'b00}, ($urandom << DUR_W) | APB_W'(v), rd);
		case (r)
			REG_LEAD_MARK:    tim.lead_mark = v;
			REG_LEAD_SPACE:   tim.lead_space = v;
			REG_BIT_MARK:     tim.bit_mark = v;
			REG_ZERO_SPACE:   tim.zero_space = v;
			REG_ONE_SPACE:    tim.one_space = v;
			REG_REPEAT_SPACE: tim.repeat_space = v;
			REG_TOLERANCE:    tim.tolerance = v;
			default: ;
		endcase
		apb_access(1'b0, {r, 2'b00}, '0, rd);
		if (rd[DUR_W-1:0] !== v) begin
			mismatches++;
			if (mismatches <= MAX_SHOWN)
				$display("readback reg %0d: expected %0d, got %0d", r, v, rd[DUR_W-1:0]);
		end
	endtask

	task automatic build_burst(input int len, input logic [31:0] data, input logic jit,
			input logic noise);
		symbol_t s;
		int      i;
		burst_q.delete();
		for (i = 0; i < len; i++) begin
			if (noise) begin
				s.mark = $urandom_range(0, DUR_MAX);
				s.space = $urandom_range(0, DUR_MAX);
			end else if (i == 0) begin
				s.mark = near(tim.lead_mark, jit);
				s.space = near(len == REPEAT_SYMBOLS ? tim.repeat_space : tim.lead_space, jit);
			end else if (i <= LAST_DATA_IDX && len != REPEAT_SYMBOLS) begin
				s.mark = near(tim.bit_mark, jit);
				s.space = near(data[i-1] ? tim.one_space : tim.zero_space, jit);
			end else begin
				s.mark = near(tim.bit_mark, jit);
				s.space = $urandom_range(0, DUR_MAX);
			end
			s.eob = (i == len - 1);
			burst_q.push_back(s);
		end
	endtask

	task automatic corrupt_one();
		symbol_t s;
		int      at;
		int      v;
		at = $urandom_range(0, burst_q.size() - 1);
		s = burst_q[at];
		case ($urandom_range(0, 2))
			0: begin
				s.mark = $urandom_range(0, DUR_MAX);
				s.space = $urandom_range(0, DUR_MAX);
			end
			1: begin
				// just outside the mark window
				v = int'(tim.bit_mark) + int'(tim.tolerance);
				s.mark = (v > int'(DUR_MAX)) ? DUR_MAX : v[DUR_W-1:0];
			end
			default: begin
				v = (int'(tim.zero_space) + int'(tim.one_space)) / 2;
				s.space = v[DUR_W-1:0];
			end
		endcase
		burst_q[at] = s;
	endtask

	task automatic send_symbol(input symbol_t sym, input logic known, input decode_t want);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		mark_duration <= sym.mark;
		space_duration <= sym.space;
		end_of_burst <= sym.eob;
		// hold the request until it is taken
		do
			@(posedge clk);
		while (in_stall);
		decode_symbol(sym, known, want);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_burst(input logic known, input decode_t want);
		foreach (burst_q[i])
			send_symbol(burst_q[i], known, want);
	endtask

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin : result_check
		decode_t e;
		if (arst_n && out_valid && !out_stall) begin
			decoded++;
			if (decodes_due.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_SHOWN)
					$display("unexpected result: status %0d address %h command %h",
						status, address, command);
			end else begin
				e = decodes_due.pop_front();
				if (status !== e.status || address !== e.address || command !== e.command) begin
					mismatches++;
					if (mismatches <= MAX_SHOWN)
						$display("decode: expected %0d %h %h, got %0d %h %h",
							e.status, e.address, e.command, status, address, command);
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			quiet = 0;
		else
			quiet++;
		if (quiet >= STALL_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin : stimulus
		burst_row_t       row;
		symbol_t          s;
		logic [DUR_W-1:0] nv [7];
		logic [APB_W-1:0] rd;
		logic [31:0]      data;
		int               p;
		int               i;
		int               pick;
		int               n;
		int               first_item;
		int               first_done;

		tim = {RST_LEAD_MARK, RST_LEAD_SPACE, RST_BIT_MARK, RST_ZERO_SPACE,
			RST_ONE_SPACE, RST_REPEAT_SPACE, RST_TOLERANCE};
		sym_cnt = '0;
		frame_ok = 1'b1;
		bits_sr = '0;
		lead_rep = 1'b0;
		addr_q = '0;
		cmd_q = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < DIR_ROWS; i++) begin
			row = burst_tab[i];
			build_burst(row.len, row.data, 1'b0, 1'b0);
			if (row.hit >= 0) begin
				s = burst_q[row.hit];
				s.mark = row.hit_mark;
				s.space = row.hit_space;
				burst_q[row.hit] = s;
			end
			send_burst(row.known, row.want);
		end

		for (p = 0; p < PHASES; p++) begin
			// timing registers change only with the decoder empty
			in_valid <= 1'b0;
			while (decodes_due.size() != 0)
				@(negedge clk);
			repeat (SETTLE) @(negedge clk);
			case (p)
				0: nv = '{RST_LEAD_MARK, RST_LEAD_SPACE, RST_BIT_MARK, RST_ZERO_SPACE,
					RST_ONE_SPACE, RST_REPEAT_SPACE, RST_TOLERANCE};
				1: nv = '{default: '0};
				2: nv = '{default: DUR_MAX};
				3: nv = '{DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, DUR_MAX, 15'd1};
				// bit mark narrower than the tolerance
				4: nv = '{RST_LEAD_MARK, RST_LEAD_SPACE, 15'd100, RST_ZERO_SPACE,
					RST_ONE_SPACE, RST_REPEAT_SPACE, 15'd300};
				// overlapping zero and one windows
				5: nv = '{RST_LEAD_MARK, RST_LEAD_SPACE, RST_BIT_MARK, 15'd1000,
					15'd1100, RST_REPEAT_SPACE, RST_TOLERANCE};
				default: begin
					foreach (nv[j])
						nv[j] = $urandom_range(0, DUR_MAX);
					nv[REG_TOLERANCE] = $urandom_range(1, 2000);
				end
			endcase
			for (i = 0; i < 7; i++)
				set_timing(reg_idx_t'(i), nv[i]);
			if (p == 0)
				apb_access(1'b1, ADDR_UNUSED, '1, rd);

			case (p % 4)
				0: begin
					idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					idle_pct = 60;
					stall_pct = 0;
				end
				2: begin
					idle_pct = 0;
					stall_pct = 60;
				end
				default: begin
					idle_pct = 11;
					stall_pct = 11;
				end
			endcase

			first_item = sent;
			first_done = decoded;
			while (sent - first_item < PHASE_ITEMS || decoded - first_done < PHASE_BURSTS) begin
				pick = $urandom_range(0, 99);
				data = $urandom;
				if (pick < 53) begin
					build_burst(FRAME_SYMBOLS, data, 1'b1, 1'b0);
					if (pick >= 45)
						corrupt_one();
				end else if (pick < 78) begin
					build_burst(REPEAT_SYMBOLS, data, 1'b1, 1'b0);
					if (pick >= 74)
						corrupt_one();
				end else begin
					n = ($urandom_range(0, 4) == 0) ? $urandom_range(35, 170) :
						$urandom_range(1, 40);
					build_burst(n, data, 1'b1, pick >= 90);
				end
				send_burst(1'b0, '0);
			end
		end

		in_valid <= 1'b0;
		while (decodes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

/* nec_ir_frame_decoder_unit.f */
+incdir+hw/rtl
hw/rtl/nir_pkg.sv
hw/rtl/nir_front.sv
hw/rtl/nir_queue.sv
hw/rtl/nir_back.sv
hw/rtl/nec_ir_frame_decoder_unit.sv
dv/nec_ir_frame_decoder_unit_test.sv
